>>> hdl/lvb_pkg.sv
// Shared constants for the light view basis pipeline.
// No dependencies; used by lvb_norm and the core.
package lvb_pkg;
    localparam int NORM_GUARD = 14;
    localparam int OUT_W      = 16;
endpackage

>>> hdl/lvb_norm.sv
// Pipelined 3-vector normalizer: sum of squares, one root step per stage,
// one quotient bit per stage. Depends on lvb_pkg.
module lvb_norm #(
    parameter int VW  = 17,
    parameter int FB  = 14,
    parameter int SBW = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [VW-1:0]   in_vx,
    input  logic signed [VW-1:0]   in_vy,
    input  logic signed [VW-1:0]   in_vz,
    input  logic [SBW-1:0]         in_sb,
    output logic                   out_valid,
    output logic signed [FB+1:0]   out_x,
    output logic signed [FB+1:0]   out_y,
    output logic signed [FB+1:0]   out_z,
    output logic [SBW-1:0]         out_sb
);
    import lvb_pkg::*;

    localparam int MW  = VW;
    localparam int SW  = 2 * MW + 2;
    localparam int RW0 = SW + 2 * NORM_GUARD;
    localparam int RW  = RW0 + (RW0 % 2);
    localparam int NS  = RW / 2;
    localparam int NW  = MW + FB + NORM_GUARD;
    localparam int QB  = FB + 1;
    localparam int DW  = NW + NS + QB + 2;
    localparam int OW  = FB + 2;
    localparam logic [QB-1:0] ONE_Q = QB'(1) << FB;

    typedef struct packed {
        logic [2:0][MW-1:0] mag;
        logic [2:0]         neg;
        logic               zero;
        logic [SBW-1:0]     sb;
    } ctx_t;

    function automatic logic [MW-1:0] absv(input logic signed [VW-1:0] v);
        return v[VW-1] ? MW'(-v) : MW'(v);
    endfunction

    // input stage
    ctx_t ctx_a_reg;
    logic va_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_a_reg.mag[0] <= absv(in_vx);
            ctx_a_reg.mag[1] <= absv(in_vy);
            ctx_a_reg.mag[2] <= absv(in_vz);
            ctx_a_reg.neg    <= {in_vz[VW-1], in_vy[VW-1], in_vx[VW-1]};
            ctx_a_reg.zero   <= 1'b0;
            ctx_a_reg.sb     <= in_sb;
        end
    end

    // squares
    ctx_t ctx_b_reg;
    logic vb_reg;
    logic [2*MW-1:0] sq_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_b_reg <= ctx_a_reg;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= ctx_a_reg.mag[i] * ctx_a_reg.mag[i];
            end
        end
    end

    // sum, then square root one step per stage
    logic [SW-1:0] sum;
    assign sum = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);

    ctx_t ctx_b_z;
    always_comb begin
        ctx_b_z      = ctx_b_reg;
        ctx_b_z.zero = (sum == '0);
    end

    logic [RW-1:0] rem_reg [0:NS];
    logic [RW-1:0] res_reg [0:NS];
    ctx_t          ctx_s_reg [0:NS];
    logic          vs_reg [0:NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg[0] <= 1'b0;
        end else if (en) begin
            vs_reg[0] <= vb_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]   <= RW'(sum) << (2 * NORM_GUARD);
            res_reg[0]   <= '0;
            ctx_s_reg[0] <= ctx_b_z;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_root
        localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * k);
        logic [RW-1:0] trial;
        assign trial = res_reg[k] + BIT;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vs_reg[k+1] <= 1'b0;
            end else if (en) begin
                vs_reg[k+1] <= vs_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                ctx_s_reg[k+1] <= ctx_s_reg[k];
                if (rem_reg[k] >= trial) begin
                    rem_reg[k+1] <= rem_reg[k] - trial;
                    res_reg[k+1] <= (res_reg[k] >> 1) + BIT;
                end else begin
                    rem_reg[k+1] <= rem_reg[k];
                    res_reg[k+1] <= res_reg[k] >> 1;
                end
            end
        end
    end

    // rounded division, one quotient bit per stage
    logic [NS-1:0] len;
    assign len = res_reg[NS][NS-1:0];

    logic [DW-1:0] dr_reg  [0:QB][3];
    logic [QB-1:0] q_reg   [0:QB][3];
    logic [DW-1:0] den_reg [0:QB];
    ctx_t          ctx_d_reg [0:QB];
    logic          vd_reg [0:QB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg[0] <= 1'b0;
        end else if (en) begin
            vd_reg[0] <= vs_reg[NS];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_d_reg[0] <= ctx_s_reg[NS];
            den_reg[0]   <= DW'(len) << 1;
            for (int i = 0; i < 3; i++) begin
                dr_reg[0][i] <= ((DW'(ctx_s_reg[NS].mag[i]) << (FB + NORM_GUARD)) << 1)
                                + DW'(len);
                q_reg[0][i]  <= '0;
            end
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int SH = QB - 1 - j;
        logic [DW-1:0] trial;
        assign trial = den_reg[j] << SH;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vd_reg[j+1] <= 1'b0;
            end else if (en) begin
                vd_reg[j+1] <= vd_reg[j];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                ctx_d_reg[j+1] <= ctx_d_reg[j];
                den_reg[j+1]   <= den_reg[j];
                for (int i = 0; i < 3; i++) begin
                    if (dr_reg[j][i] >= trial) begin
                        dr_reg[j+1][i] <= dr_reg[j][i] - trial;
                        q_reg[j+1][i]  <= q_reg[j][i] | (QB'(1) << SH);
                    end else begin
                        dr_reg[j+1][i] <= dr_reg[j][i];
                        q_reg[j+1][i]  <= q_reg[j][i];
                    end
                end
            end
        end
    end

    // clamp, sign, zero vector
    logic signed [OW-1:0] o_next [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [QB-1:0] qc;
            qc = (q_reg[QB][i] > ONE_Q) ? ONE_Q : q_reg[QB][i];
            if (ctx_d_reg[QB].zero) begin
                o_next[i] = '0;
            end else if (ctx_d_reg[QB].neg[i]) begin
                o_next[i] = -$signed(OW'(qc));
            end else begin
                o_next[i] = $signed(OW'(qc));
            end
        end
    end

    logic                 vo_reg;
    logic signed [OW-1:0] ox_reg, oy_reg, oz_reg;
    logic [SBW-1:0]       osb_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= vd_reg[QB];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ox_reg  <= o_next[0];
            oy_reg  <= o_next[1];
            oz_reg  <= o_next[2];
            osb_reg <= ctx_d_reg[QB].sb;
        end
    end

    assign out_valid = vo_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign out_sb    = osb_reg;
endmodule

>>> hdl/light_view_basis_from_direction_core.sv
// Light view basis core: right, up and forward axes of a view rotation.
// Depends on lvb_pkg and lvb_norm.
//
// Takes one direction beat per clock and returns one basis beat per clock unless an output beat waits.
// Pipeline order at FB=14: input register, right/forward normalizers
// (each 32 root steps, FB+1 quotient steps), two cross-product stages,
// up normalizer (35 root steps, FB+1 quotient steps) and the
// output register. The whole pipeline holds while an output beat waits.
// A direction with zero x and z gives right=(1,0,0) and sets vertical_case.
module light_view_basis_from_direction_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [lvb_pkg::OUT_W-1:0]    s_dir_x,
    input  logic signed [lvb_pkg::OUT_W-1:0]    s_dir_y,
    input  logic signed [lvb_pkg::OUT_W-1:0]    s_dir_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lvb_pkg::OUT_W-1:0]    m_right_x,
    output logic signed [lvb_pkg::OUT_W-1:0]    m_right_y,
    output logic signed [lvb_pkg::OUT_W-1:0]    m_right_z,
    output logic signed [lvb_pkg::OUT_W-1:0]    m_upvec_x,
    output logic signed [lvb_pkg::OUT_W-1:0]    m_upvec_y,
    output logic signed [lvb_pkg::OUT_W-1:0]    m_upvec_z,
    output logic signed [lvb_pkg::OUT_W-1:0]    m_fwd_x,
    output logic signed [lvb_pkg::OUT_W-1:0]    m_fwd_y,
    output logic signed [lvb_pkg::OUT_W-1:0]    m_fwd_z,
    output logic                                m_vertical_case
);
    import lvb_pkg::*;

    localparam int FB  = FRAC_BITS;
    localparam int OW  = FB + 2;
    localparam int DXW = OUT_W + 1;
    localparam int PW  = OUT_W + OW;
    localparam int DFW = PW + 1;
    localparam int UW  = DFW - FB + 1;
    localparam int SB2 = 6 * OW + 1;
    localparam logic signed [OW-1:0] ONE_S = OW'(1) << FB;
    localparam logic [DFW-1:0] HALF = DFW'(1) << (FB - 1);

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [OW:0] v);
        logic signed [47:0] w;
        w = 48'(v);
        if (w > 48'sd32767) begin
            return 16'sh7fff;
        end else if (w < -48'sd32768) begin
            return 16'sh8000;
        end
        return w[OUT_W-1:0];
    endfunction

    function automatic logic signed [UW-1:0] descale(input logic signed [DFW-1:0] p);
        logic [DFW-1:0] m;
        logic [DFW-1:0] q;
        m = p[DFW-1] ? DFW'(-p) : DFW'(p);
        q = (m + HALF) >> FB;
        return p[DFW-1] ? -$signed(q[UW-1:0]) : $signed(q[UW-1:0]);
    endfunction

    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // input register
    logic                     v0_reg;
    logic signed [OUT_W-1:0]  dx_reg, dy_reg, dz_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= s_dir_x;
            dy_reg <= s_dir_y;
            dz_reg <= s_dir_z;
        end
    end

    logic signed [DXW-1:0] dx17, dy17, dz17, ndx17;
    logic                  vert0;
    assign dx17  = DXW'(dx_reg);
    assign dy17  = DXW'(dy_reg);
    assign dz17  = DXW'(dz_reg);
    assign ndx17 = -dx17;
    assign vert0 = (dx_reg == '0) && (dz_reg == '0);

    // right and forward normalizers in parallel
    logic                   n1_valid;
    logic signed [OW-1:0]   r1_x, r1_y, r1_z;
    logic [3*OUT_W-1:0]     n1_sb;
    logic signed [OW-1:0]   f_x, f_y, f_z;
    logic                   vert1;

    lvb_norm #(.VW(DXW), .FB(FB), .SBW(3*OUT_W)) u_norm_right (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v0_reg),
        .in_vx(dz17), .in_vy('0), .in_vz(ndx17),
        .in_sb({dx_reg, dy_reg, dz_reg}),
        .out_valid(n1_valid), .out_x(r1_x), .out_y(r1_y), .out_z(r1_z),
        .out_sb(n1_sb)
    );

    lvb_norm #(.VW(DXW), .FB(FB), .SBW(1)) u_norm_fwd (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v0_reg),
        .in_vx(dx17), .in_vy(dy17), .in_vz(dz17), .in_sb(vert0),
        .out_valid(), .out_x(f_x), .out_y(f_y), .out_z(f_z), .out_sb(vert1)
    );

    logic signed [OUT_W-1:0] d1x, d1y, d1z;
    logic signed [OW-1:0]    rx, ry, rz;
    assign d1x = n1_sb[3*OUT_W-1:2*OUT_W];
    assign d1y = n1_sb[2*OUT_W-1:OUT_W];
    assign d1z = n1_sb[OUT_W-1:0];
    assign rx  = vert1 ? ONE_S : r1_x;
    assign ry  = vert1 ? '0 : r1_y;
    assign rz  = vert1 ? '0 : r1_z;

    // cross product: products
    logic                 v1_reg;
    logic signed [PW-1:0] p_reg [6];
    logic [SB2-1:0]       sb1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= n1_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= PW'(d1y) * PW'(rz);
            p_reg[1] <= PW'(d1z) * PW'(ry);
            p_reg[2] <= PW'(d1z) * PW'(rx);
            p_reg[3] <= PW'(d1x) * PW'(rz);
            p_reg[4] <= PW'(d1x) * PW'(ry);
            p_reg[5] <= PW'(d1y) * PW'(rx);
            sb1_reg  <= {rx, ry, rz, f_x, f_y, f_z, vert1};
        end
    end

    // cross product: differences and descale
    logic                 v2_reg;
    logic signed [UW-1:0] ux_reg, uy_reg, uz_reg;
    logic [SB2-1:0]       sb2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ux_reg  <= descale(DFW'(p_reg[0]) - DFW'(p_reg[1]));
            uy_reg  <= descale(DFW'(p_reg[2]) - DFW'(p_reg[3]));
            uz_reg  <= descale(DFW'(p_reg[4]) - DFW'(p_reg[5]));
            sb2_reg <= sb1_reg;
        end
    end

    // up normalizer
    logic                 n2_valid;
    logic signed [OW-1:0] u_x, u_y, u_z;
    logic [SB2-1:0]       n2_sb;
    lvb_norm #(.VW(UW), .FB(FB), .SBW(SB2)) u_norm_up (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2_reg),
        .in_vx(ux_reg), .in_vy(uy_reg), .in_vz(uz_reg), .in_sb(sb2_reg),
        .out_valid(n2_valid), .out_x(u_x), .out_y(u_y), .out_z(u_z),
        .out_sb(n2_sb)
    );

    logic signed [OW-1:0] o_rx, o_ry, o_rz, o_fx, o_fy, o_fz;
    logic                 o_vert;
    assign {o_rx, o_ry, o_rz, o_fx, o_fy, o_fz, o_vert} = n2_sb;

    // output register
    logic signed [OUT_W-1:0] rx_reg, ry_reg, rz_reg, ux_o_reg, uy_o_reg, uz_o_reg;
    logic signed [OUT_W-1:0] fx_reg, fy_reg, fz_reg;
    logic                    vert_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= n2_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg   <= sat((OW+1)'(o_rx));
            ry_reg   <= sat((OW+1)'(o_ry));
            rz_reg   <= sat((OW+1)'(o_rz));
            ux_o_reg <= sat((OW+1)'(u_x));
            uy_o_reg <= sat((OW+1)'(u_y));
            uz_o_reg <= sat((OW+1)'(u_z));
            fx_reg   <= sat(-((OW+1)'(o_fx)));
            fy_reg   <= sat(-((OW+1)'(o_fy)));
            fz_reg   <= sat(-((OW+1)'(o_fz)));
            vert_reg <= o_vert;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_right_x       = rx_reg;
    assign m_right_y       = ry_reg;
    assign m_right_z       = rz_reg;
    assign m_upvec_x       = ux_o_reg;
    assign m_upvec_y       = uy_o_reg;
    assign m_upvec_z       = uz_o_reg;
    assign m_fwd_x         = fx_reg;
    assign m_fwd_y         = fy_reg;
    assign m_fwd_z         = fz_reg;
    assign m_vertical_case = vert_reg;

`ifndef ASSERT_OFF
    a_right_y_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_right_y == '0)
        else $error("right axis has nonzero y");
    a_vert_right: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_vertical_case |-> m_right_z == '0 && m_right_x != '0)
        else $error("vertical case right axis wrong");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_upvec_x) && $stable(m_fwd_z))
        else $error("stalled output changed");
`endif
endmodule
